FILE: hdl/signed_integer_to_radix_ascii_macros.svh
// Assertion macros for the signed integer to radix ASCII converter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SIGNED_INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SITRA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SITRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sitra_pkg.sv
// Package for the signed integer to radix ASCII converter.
// Holds widths, radix limits, FSM and divider types and the glyph function.
`default_nettype none
package sitra_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int RADIX_WIDTH     = 6;
   localparam int CHAR_WIDTH      = 8;
   localparam int MAX_DIGITS      = 64;
   localparam int DIGIT_IDX_WIDTH = $clog2(MAX_DIGITS);
   localparam int COUNT_WIDTH     = DIGIT_IDX_WIDTH + 1;
   localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(36);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30; // '0'
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA  = 8'h37; // 'A' - 10
   localparam logic [CHAR_WIDTH-1:0] CHAR_ERROR  = 8'h00;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_LOAD,
      S_ERR
   } state_type;

   typedef struct packed {
      logic                   load;
      logic                   start;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [RADIX_WIDTH-1:0] radix;
   } div_ctrl_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic                   quot_zero;
      logic [RADIX_WIDTH-1:0] digit;
   } div_status_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_glyph(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] g;
      if (d < RADIX_WIDTH'(10)) begin
         g = CHAR_ZERO + CHAR_WIDTH'(d);
      end else if (d < RADIX_MAX) begin
         g = CHAR_ALPHA + CHAR_WIDTH'(d);
      end else begin
         g = CHAR_ZERO;
      end
      return g;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sitra_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on sitra_pkg for field widths.
`default_nettype none
interface sitra_req_if import sitra_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [RADIX_WIDTH-1:0]        radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sitra_rsp_if import sitra_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  negative;
   logic                  error;
   logic                  last;

   modport source (output valid, output character, output negative, output error,
                   output last, input ready);
   modport sink   (input valid, input character, input negative, input error,
                   input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/sitra_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, quotient in place.
// Depends on sitra_pkg for widths and the control/status structs.
`default_nettype none
module sitra_divider import sitra_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire div_ctrl_type   ctrl,
   output      div_status_type status
);

   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [RADIX_WIDTH-1:0]   rem_ff, rem_in;
   logic [BIT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     nz_ff, nz_in;
   logic [RADIX_WIDTH-1:0]   radix_ff, radix_in;

   logic [RADIX_WIDTH:0]     trial;
   logic [RADIX_WIDTH:0]     diff;
   logic                     ge;
   logic [RADIX_WIDTH-1:0]   rem_step;
   logic                     last_bit;

   always_comb begin
      trial    = {rem_ff, mag_ff[VALUE_WIDTH-1]};
      diff     = trial - {1'b0, radix_ff};
      ge       = trial >= {1'b0, radix_ff};
      rem_step = ge ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
      last_bit = cnt_ff == BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
   end

   always_comb begin
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      nz_in    = nz_ff;
      radix_in = radix_ff;
      // shift one dividend bit in, one quotient bit out
      if (busy_ff) begin
         mag_in = {mag_ff[VALUE_WIDTH-2:0], ge};
         rem_in = rem_step;
         cnt_in = cnt_ff + BIT_CNT_WIDTH'(1);
         nz_in  = nz_ff | ge;
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
      if (ctrl.load) begin
         mag_in   = ctrl.magnitude;
         radix_in = ctrl.radix;
      end
      if (ctrl.start) begin
         rem_in  = '0;
         cnt_in  = '0;
         nz_in   = 1'b0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      nz_ff    <= nz_in;
      radix_ff <= radix_in;
   end

   always_comb begin
      status.busy      = busy_ff;
      status.done      = busy_ff && last_bit;
      status.quot_zero = !(nz_ff || ge);
      status.digit     = rem_step;
   end

endmodule
`default_nettype wire

FILE: hdl/signed_integer_to_radix_ascii.sv
// Operation: each digit takes one full pass of the bit-serial divider, one quotient
//   bit per cycle; each character is then read from the digit store and loaded.
// Requests: a new request is taken only in idle, after the last character is loaded;
//   response stalls hold the output register; a bad radix gives one error character.
// Reset: synchronous, active high; clears the FSM, counters and output valid.
//   The digit store is not cleared; every entry is written before it is read.
`default_nettype none
module signed_integer_to_radix_ascii import sitra_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   sitra_req_if.sink   req,
   sitra_rsp_if.source rsp
);

`include "signed_integer_to_radix_ascii_macros.svh"

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;      // digits produced so far
   logic [DIGIT_IDX_WIDTH-1:0] idx_ff, idx_in;        // next digit to emit
   logic                     sign_ff, sign_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    char_ff, char_in;
   logic                     neg_ff, neg_in;
   logic                     err_ff, err_in;
   logic                     last_ff, last_in;

   // Digit store, least significant digit at index 0
   logic [RADIX_WIDTH-1:0]   digit_mem [MAX_DIGITS];
   logic [RADIX_WIDTH-1:0]   rd_data_ff;

   div_ctrl_type             div_ctrl;
   div_status_type           div_status;

   logic                     accept;
   logic                     radix_ok;
   logic                     slot_free;
   logic                     div_stop;
   logic [VALUE_WIDTH-1:0]   raw_value;
   logic [VALUE_WIDTH-1:0]   magnitude;
   logic                     value_neg;

   // FSM outputs
   logic                     mem_we;
   logic                     load_digit;
   logic                     load_error;
   logic                     div_load;
   logic                     div_start;

   // ---------------------------------------------------------------
   // Input decode: magnitude taken unsigned so the most negative value
   // converts exactly.
   // ---------------------------------------------------------------
   always_comb begin
      req.ready = (state_ff == S_IDLE) && !reset;
      accept    = req.valid && req.ready;
      radix_ok  = req.radix inside {[RADIX_MIN:RADIX_MAX]};
      raw_value = req.value;
      value_neg = raw_value[VALUE_WIDTH-1];
      magnitude = value_neg ? (~raw_value + VALUE_WIDTH'(1)) : raw_value;
      slot_free = !rsp_valid_ff || rsp.ready;
      // stop when the quotient runs out or the store is full
      div_stop  = div_status.quot_zero ||
                  count_ff == COUNT_WIDTH'(MAX_DIGITS - 1);
   end

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = radix_ok ? S_DIV : S_ERR;
            end
         end
         S_DIV: begin
            if (div_status.done && div_stop) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (slot_free) begin
               state_in = (idx_ff == '0) ? S_IDLE : S_READ;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // FSM outputs
   // ---------------------------------------------------------------
   always_comb begin
      mem_we     = 1'b0;
      load_digit = 1'b0;
      load_error = 1'b0;
      div_load   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            div_load  = accept && radix_ok;
            div_start = accept && radix_ok;
         end
         S_DIV: begin
            // write each remainder; chain straight into the next pass
            mem_we    = div_status.done;
            div_start = div_status.done && !div_stop;
         end
         S_LOAD: begin
            load_digit = slot_free;
         end
         S_ERR: begin
            load_error = slot_free;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      div_ctrl.load      = div_load;
      div_ctrl.start     = div_start;
      div_ctrl.magnitude = magnitude;
      div_ctrl.radix     = req.radix;
   end

   sitra_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_status)
   );

   // ---------------------------------------------------------------
   // Counters and held sign
   // ---------------------------------------------------------------
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      sign_in  = sign_ff;
      if (accept) begin
         count_in = '0;
         sign_in  = radix_ok && value_neg;
      end
      if (mem_we) begin
         count_in = count_ff + COUNT_WIDTH'(1);
         if (div_stop) begin
            idx_in = count_ff[DIGIT_IDX_WIDTH-1:0];
         end
      end
      if (load_digit && idx_ff != '0) begin
         idx_in = idx_ff - DIGIT_IDX_WIDTH'(1);
      end
   end

   // ---------------------------------------------------------------
   // Output register: hold until taken, load a new character into a free slot
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      char_in      = char_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      if (load_digit) begin
         rsp_valid_in = 1'b1;
         char_in      = digit_glyph(rd_data_ff);
         neg_in       = sign_ff;
         err_in       = 1'b0;
         last_in      = idx_ff == '0;
      end else if (load_error) begin
         rsp_valid_in = 1'b1;
         char_in      = CHAR_ERROR;
         neg_in       = 1'b0;
         err_in       = 1'b1;
         last_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      neg_ff  <= neg_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   // Digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[count_ff[DIGIT_IDX_WIDTH-1:0]] <= div_status.digit;
      end
      rd_data_ff <= digit_mem[idx_ff];
   end

   always_comb begin
      rsp.valid     = rsp_valid_ff;
      rsp.character = char_ff;
      rsp.negative  = neg_ff;
      rsp.error     = err_ff;
      rsp.last      = last_ff;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `SITRA_ASSERT_NOW(a_done_in_div, div_status.done, state_ff == S_DIV, "divider done outside DIV")
   `SITRA_ASSERT_NOW(a_store_bound, mem_we, count_ff < COUNT_WIDTH'(MAX_DIGITS), "digit store overrun")
   `SITRA_ASSERT_NOW(a_error_shape, rsp_valid_ff && err_ff, last_ff && char_ff == CHAR_ERROR && !neg_ff, "malformed error response")
   `SITRA_ASSERT_NEXT(a_bad_radix, accept && !radix_ok, state_ff == S_ERR, "bad radix not flagged")

endmodule
`default_nettype wire
